### sv/cpts_pkg.sv
// ----------------------------------------------------------------------------
// cpts_pkg
// Shared widths, constants and the task record layout of the scheduler.
// ----------------------------------------------------------------------------
package cpts_pkg;

  localparam int TASK_SLOTS = 64;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int IDX_W      = $clog2(TASK_SLOTS + 1);

  // Fixed port widths
  localparam int OP_W       = 3;
  localparam int PORT_SLOT_W = 6;
  localparam int PRIO_W     = 8;

  localparam int TIME_W     = 9;
  localparam int LOCK_W     = 4;
  localparam logic [LOCK_W-1:0] LOCK_MAX = 4'd15;

  // Operation codes; the two top codes are reserved and do nothing
  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_YIELD  = 3'd1,
    OP_EXIT   = 3'd2,
    OP_LOCK   = 3'd3,
    OP_UNLOCK = 3'd4,
    OP_CREATE = 3'd5,
    OP_RSVD6  = 3'd6,
    OP_RSVD7  = 3'd7
  } op_t;

  // One task slot, minus its priority (kept in a memory of its own)
  typedef struct packed {
    logic              used;
    logic              running;
    logic [TIME_W-1:0] time_left;
    logic [LOCK_W-1:0] lock_depth;
  } task_rec_t;

  localparam int REC_W = $bits(task_rec_t);

endpackage

### sv/counter_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler
// Counter-based priority task scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: operation, slot and
//   priority_req. Every item yields exactly one result on the output channel
//   (out_valid/out_ready): current_slot, switched, aged.
//   cfg_wr_en/cfg_wr_data write the priority of slot zero at once (zero is
//   stored as 1). Write only while idle.
// Flow:
//   The slot table sits in a single-port-read task memory plus a priority
//   memory, both with registered reads. When nothing is rescheduled the
//   result is posted after the modify step; a pick adds a scan with one
//   memory read per slot, and when every running counter is empty an
//   aging pass follows the scan (the aging pass also makes the final pick).
//   One item is in work at a time; the next is taken the cycle after a
//   result is posted.
// Reset:
//   rst clears the valid bits of both memories so every slot reads its reset
//   value; no clearing pass. Slot zero is used and running, priority 1.
// Stall:
//   A finished result is held in the output register. The next item is taken
//   while it waits; its own result waits until the output register frees.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler (
  input  logic                             clk,
  input  logic                             rst,
  // config
  input  logic                             cfg_wr_en,
  input  logic [cpts_pkg::PRIO_W-1:0]      cfg_wr_data,
  // input item
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cpts_pkg::OP_W-1:0]        operation,
  input  logic [cpts_pkg::PORT_SLOT_W-1:0] slot,
  input  logic [cpts_pkg::PRIO_W-1:0]      priority_req,
  // result item
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cpts_pkg::PORT_SLOT_W-1:0] current_slot,
  output logic                             switched,
  output logic                             aged
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_AGE,
    S_DONE
  } state_t;

  localparam int SLOT_W = cpts_pkg::SLOT_W;
  localparam int IDX_W  = cpts_pkg::IDX_W;
  localparam int TIME_W = cpts_pkg::TIME_W;
  localparam int PRIO_W = cpts_pkg::PRIO_W;
  localparam int LOCK_W = cpts_pkg::LOCK_W;

  // Slot zero after reset: used, running, no time, no lock
  localparam cpts_pkg::task_rec_t SLOT0_REC = '{used: 1'b1, running: 1'b1,
                                                time_left: '0, lock_depth: '0};

  function automatic logic [PRIO_W-1:0] fix_prio(input logic [PRIO_W-1:0] p);
    fix_prio = (p == '0) ? PRIO_W'(1) : p;
  endfunction

  state_t state;

  // Latched item
  cpts_pkg::op_t                    op_q;
  logic [cpts_pkg::PORT_SLOT_W-1:0] slot_q;
  logic [PRIO_W-1:0]                prio_q;

  logic [SLOT_W-1:0] running_slot;

  // Scan bookkeeping
  logic [IDX_W-1:0]  idx;
  logic              pend;
  logic [SLOT_W-1:0] pend_idx;
  logic              found;
  logic [SLOT_W-1:0] best;
  logic [TIME_W-1:0] best_cnt;
  logic [SLOT_W-1:0] pick_slot;
  logic              pick_aged;

  // Memories
  cpts_pkg::task_rec_t task_mem [cpts_pkg::TASK_SLOTS];
  logic [PRIO_W-1:0]   prio_mem [cpts_pkg::TASK_SLOTS];
  logic [cpts_pkg::TASK_SLOTS-1:0] task_vld;
  logic [cpts_pkg::TASK_SLOTS-1:0] prio_vld;

  cpts_pkg::task_rec_t mem_rd, task_rd, mem_wd;
  logic [PRIO_W-1:0]   prio_rd, prio_cur, prio_wd;
  logic                rd_vld, prio_rd_vld, rd_zero;
  logic [SLOT_W-1:0]   mem_ra, mem_wa, prio_wa;
  logic                mem_we, prio_we;

  // Per-item decode
  logic              issue;
  logic [TIME_W-1:0] t_dec;
  logic [TIME_W-1:0] t_aged;
  logic              resched;
  logic              create_ok;
  logic              cand;

  assign in_ready  = (state == S_IDLE);
  assign issue     = (idx != IDX_W'(cpts_pkg::TASK_SLOTS));
  assign create_ok = ({3'b000, slot_q} < 9'(cpts_pkg::TASK_SLOTS));

  // Entries never written read as their reset value
  assign task_rd  = rd_vld ? mem_rd : (rd_zero ? SLOT0_REC : '0);
  assign prio_cur = prio_rd_vld ? prio_rd : (rd_zero ? PRIO_W'(1) : '0);

  assign t_dec  = (task_rd.time_left != '0) ? task_rd.time_left - TIME_W'(1) : '0;
  assign t_aged = (task_rd.time_left >> 1) + TIME_W'(prio_cur);
  assign cand   = task_rd.used & task_rd.running;

  // Read address
  always_comb begin
    case (state)
      S_SCAN, S_AGE: mem_ra = idx[SLOT_W-1:0];
      default:       mem_ra = running_slot;
    endcase
  end

  // Write port and reschedule decision
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = running_slot;
    mem_wd  = task_rd;
    prio_we = 1'b0;
    prio_wa = '0;
    prio_wd = fix_prio(cfg_wr_data);
    resched = 1'b0;
    case (state)
      S_MOD: begin
        case (op_q)
          cpts_pkg::OP_TICK: begin
            mem_we           = 1'b1;
            mem_wd.time_left = t_dec;
            resched          = (t_dec == '0) && (task_rd.lock_depth == '0);
          end
          cpts_pkg::OP_YIELD: begin
            mem_we           = 1'b1;
            mem_wd.time_left = '0;
            resched          = 1'b1;
          end
          cpts_pkg::OP_EXIT: begin
            mem_we           = 1'b1;
            mem_wd.time_left = '0;
            mem_wd.running   = task_rd.used ? 1'b0 : task_rd.running;
            resched          = 1'b1;
          end
          cpts_pkg::OP_LOCK: begin
            mem_we = 1'b1;
            if (task_rd.lock_depth != cpts_pkg::LOCK_MAX) begin
              mem_wd.lock_depth = task_rd.lock_depth + LOCK_W'(1);
            end
          end
          cpts_pkg::OP_UNLOCK: begin
            mem_we = 1'b1;
            if (task_rd.lock_depth != '0) begin
              mem_wd.lock_depth = task_rd.lock_depth - LOCK_W'(1);
            end
          end
          cpts_pkg::OP_CREATE: begin
            mem_we            = create_ok;
            mem_wa            = SLOT_W'(slot_q);
            mem_wd.used       = 1'b1;
            mem_wd.running    = 1'b1;
            mem_wd.time_left  = TIME_W'(fix_prio(prio_q));
            mem_wd.lock_depth = '0;
            prio_we           = create_ok;
            prio_wa           = SLOT_W'(slot_q);
            prio_wd           = fix_prio(prio_q);
          end
          default: begin
          end
        endcase
      end
      S_AGE: begin
        mem_we           = pend & task_rd.used;
        mem_wa           = pend_idx;
        mem_wd.time_left = t_aged;
      end
      S_IDLE: begin
        prio_we = cfg_wr_en;
      end
      default: begin
      end
    endcase
  end

  // Memory arrays
  always_ff @(posedge clk) begin
    if (mem_we) begin
      task_mem[mem_wa] <= mem_wd;
    end
    if (prio_we) begin
      prio_mem[prio_wa] <= prio_wd;
    end
    mem_rd  <= task_mem[mem_ra];
    prio_rd <= prio_mem[mem_ra];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      task_vld    <= '0;
      prio_vld    <= '0;
      rd_vld      <= 1'b0;
      prio_rd_vld <= 1'b0;
      rd_zero     <= 1'b0;
    end else begin
      if (mem_we) begin
        task_vld[mem_wa] <= 1'b1;
      end
      if (prio_we) begin
        prio_vld[prio_wa] <= 1'b1;
      end
      rd_vld      <= task_vld[mem_ra];
      prio_rd_vld <= prio_vld[mem_ra];
      rd_zero     <= (mem_ra == '0);
    end
  end

  // Control and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_slot <= '0;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
      idx          <= '0;
      found        <= 1'b0;
    end else begin
      // S_DONE drives out_valid itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q   <= cpts_pkg::op_t'(operation);
            slot_q <= slot;
            prio_q <= priority_req;
            state  <= S_MOD;
          end
        end
        S_MOD: begin
          idx      <= '0;
          pend     <= 1'b0;
          found    <= 1'b0;
          best     <= '0;
          best_cnt <= '0;
          if (resched) begin
            state <= S_SCAN;
          end else begin
            pick_slot <= running_slot;
            pick_aged <= 1'b0;
            state     <= S_DONE;
          end
        end
        S_SCAN: begin
          if (pend && cand && (!found || task_rd.time_left > best_cnt)) begin
            found    <= 1'b1;
            best     <= pend_idx;
            best_cnt <= task_rd.time_left;
          end
          if (issue) begin
            idx <= idx + IDX_W'(1);
          end
          pend     <= issue;
          pend_idx <= idx[SLOT_W-1:0];
          if (!issue && !pend) begin
            if (!found) begin
              pick_slot <= '0;
              pick_aged <= 1'b0;
              state     <= S_DONE;
            end else if (best_cnt != '0) begin
              pick_slot <= best;
              pick_aged <= 1'b0;
              state     <= S_DONE;
            end else begin
              // every running counter is empty: age all, pick on the way
              idx   <= '0;
              found <= 1'b0;
              state <= S_AGE;
            end
          end
        end
        S_AGE: begin
          if (pend && cand && (!found || t_aged > best_cnt)) begin
            found    <= 1'b1;
            best     <= pend_idx;
            best_cnt <= t_aged;
          end
          if (issue) begin
            idx <= idx + IDX_W'(1);
          end
          pend     <= issue;
          pend_idx <= idx[SLOT_W-1:0];
          if (!issue && !pend) begin
            pick_slot <= found ? best : '0;
            pick_aged <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            current_slot <= cpts_pkg::PORT_SLOT_W'(pick_slot);
            switched     <= (pick_slot != running_slot);
            aged         <= pick_aged;
            running_slot <= pick_slot;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/cpts_checker.sv
// ----------------------------------------------------------------------------
// cpts_checker
// Port-level checks of the task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module cpts_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [cpts_pkg::PORT_SLOT_W-1:0] current_slot,
  input logic                             switched,
  input logic                             aged
);

  // One item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // A result is only raised out of a state with the input side closed
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without an item in work");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_slot) &&
      $stable(switched) && $stable(aged))
    else $error("stalled result changed");

endmodule

bind counter_priority_task_scheduler cpts_checker u_cpts_checker (.*);
